// File: hdl/hfir_pkg.sv
// ----------------------------------------------------------------------------
// hfir_pkg: shared types and constants of the horizontal luma filter
// Field widths, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package hfir_pkg;

  // Field and arithmetic widths
  localparam int PIX_W     = 8;
  localparam int WT_W      = 8;
  localparam int NTAPS     = 5;
  localparam int TAP_IDX_W = 3;
  localparam int PROD_W    = WT_W + PIX_W + 1;
  localparam int ACC_W     = 19;
  localparam int MAG_W     = ACC_W - 1;
  localparam int WSUM_W    = 11;
  localparam int DIV_W     = 10;
  localparam int DSTEP_W   = 5;
  localparam int LW_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_LINE_WIDTH_DEF = 4096;
  localparam int LINE_WIDTH_RESET   = 640;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP3   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAP4   = 3'd6;

  // Source of the word loaded into the output register
  typedef enum logic [1:0] {
    SEL_CENTER = 2'd0,
    SEL_W0     = 2'd1,
    SEL_CUR    = 2'd2
  } hfir_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      capture;
    logic      mac_step;
    logic      div_setup;
    logic      div_step;
    logic      load_out;
    hfir_sel_t out_sel;
    logic      shift;
  } hfir_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic col_last;
    logic col_ge4;
    logic col_lt2;
    logic filter_on;
    logic item_last;
    logic mac_done;
    logic div_done;
    logic out_free;
  } hfir_sts_t;

endpackage

// File: hdl/hfir_dp.sv
// ----------------------------------------------------------------------------
// hfir_dp: datapath of the horizontal luma filter
// Config registers, pixel window, column counter, serial MAC, restoring
// divider, clamp and the output register.
// ----------------------------------------------------------------------------
module hfir_dp #(
  parameter int MAX_LINE_WIDTH = hfir_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hfir_pkg::hfir_cmd_t            cmd,
  output hfir_pkg::hfir_sts_t            sts,
  input  logic [hfir_pkg::PIX_W-1:0]     pixel_in,
  input  logic                           frame_end_in,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [hfir_pkg::PIX_W-1:0]     pixel_out,
  output logic                           row_last,
  output logic                           frame_last,
  input  logic                           cfg_we,
  input  logic [hfir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfir_pkg::CFG_W-1:0]     cfg_data
);
  import hfir_pkg::*;

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int EW = (CW + 1 > LW_W) ? CW + 1 : LW_W;

  // Configuration
  logic                    en_r;
  logic [LW_W-1:0]         lw_r;
  logic signed [WT_W-1:0]  wt_r [NTAPS];

  // Pixel state
  logic [PIX_W-1:0]        win_r [4];
  logic [PIX_W-1:0]        cur_r;
  logic                    fend_r;
  logic                    last_r;
  logic [CW-1:0]           col_r;

  // Arithmetic
  logic [TAP_IDX_W-1:0]    k_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [WSUM_W-1:0] wsum_r;
  logic [DIV_W-1:0]        dvs_r;
  logic [DIV_W-1:0]        rem_r;
  logic [MAG_W-1:0]        quo_r;
  logic                    neg_r;
  logic [DSTEP_W-1:0]      dcnt_r;

  // Output register
  logic                    out_valid_r;
  logic [PIX_W-1:0]        out_pix_r;
  logic                    out_rl_r;
  logic                    out_fl_r;

  // Combinational helpers
  logic [EW-1:0]            lw_ext, wmax, weff, col_ext;
  logic [PIX_W-1:0]         tap_pix;
  logic signed [WT_W-1:0]   tap_wt;
  logic signed [PROD_W-1:0] prod;
  logic signed [WSUM_W-1:0] wabs;
  logic [DIV_W:0]           trial, trial_sub;
  logic                     qbit;
  logic [PIX_W-1:0]         filt, center;
  logic [PIX_W-1:0]         sel_pix;
  logic                     sel_rl, sel_fl;

  // Effective width and column decisions
  always_comb begin
    lw_ext  = EW'(lw_r);
    wmax    = EW'(MAX_LINE_WIDTH);
    col_ext = EW'(col_r);
    if (lw_ext < EW'(4)) begin
      weff = EW'(4);
    end else if (lw_ext > wmax) begin
      weff = wmax;
    end else begin
      weff = lw_ext;
    end
  end

  assign sts.col_last  = col_ext >= (weff - EW'(1));
  assign sts.col_ge4   = col_ext >= EW'(4);
  assign sts.col_lt2   = col_ext < EW'(2);
  assign sts.filter_on = en_r;
  assign sts.item_last = last_r;
  assign sts.mac_done  = k_r == TAP_IDX_W'(NTAPS - 1);
  assign sts.div_done  = dcnt_r == DSTEP_W'(MAG_W - 1);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b0;
      lw_r     <= LW_W'(LINE_WIDTH_RESET);
      wt_r[0]  <= '0;
      wt_r[1]  <= '0;
      wt_r[2]  <= WT_W'(1);
      wt_r[3]  <= '0;
      wt_r[4]  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: en_r    <= cfg_data[0];
        REG_WIDTH:  lw_r    <= cfg_data[LW_W-1:0];
        REG_TAP0:   wt_r[0] <= cfg_data[WT_W-1:0];
        REG_TAP1:   wt_r[1] <= cfg_data[WT_W-1:0];
        REG_TAP2:   wt_r[2] <= cfg_data[WT_W-1:0];
        REG_TAP3:   wt_r[3] <= cfg_data[WT_W-1:0];
        REG_TAP4:   wt_r[4] <= cfg_data[WT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the word, advance the column, shift the window at item end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      for (int i = 0; i < 4; i++) win_r[i] <= '0;
    end else begin
      if (cmd.capture) begin
        col_r <= sts.col_last ? '0 : col_r + CW'(1);
      end
      if (cmd.shift) begin
        win_r[3] <= win_r[2];
        win_r[2] <= win_r[1];
        win_r[1] <= win_r[0];
        win_r[0] <= cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r  <= pixel_in;
      fend_r <= frame_end_in;
      last_r <= sts.col_last;
    end
  end

  // Select one tap per MAC step
  always_comb begin
    unique case (k_r)
      3'd0:    tap_pix = win_r[3];
      3'd1:    tap_pix = win_r[2];
      3'd2:    tap_pix = win_r[1];
      3'd3:    tap_pix = win_r[0];
      default: tap_pix = cur_r;
    endcase
    tap_wt = wt_r[k_r];
    prod   = tap_wt * $signed({1'b0, tap_pix});
    wabs   = wsum_r[WSUM_W-1] ? -wsum_r : wsum_r;
    trial  = {rem_r, quo_r[MAG_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    qbit   = trial >= {1'b0, dvs_r};
  end

  // Accumulate the weighted sum and the weight sum
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      k_r    <= '0;
      acc_r  <= '0;
      wsum_r <= '0;
    end else if (cmd.mac_step) begin
      k_r    <= k_r + TAP_IDX_W'(1);
      acc_r  <= acc_r + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      wsum_r <= wsum_r + {{(WSUM_W-WT_W){tap_wt[WT_W-1]}}, tap_wt};
    end
  end

  // Restoring division by the weight-sum magnitude, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_setup) begin
      dvs_r  <= (wabs == '0) ? DIV_W'(1) : wabs[DIV_W-1:0];
      quo_r  <= acc_r[MAG_W-1:0];
      neg_r  <= acc_r[ACC_W-1];
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= qbit ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_r  <= {quo_r[MAG_W-2:0], qbit};
      dcnt_r <= dcnt_r + DSTEP_W'(1);
    end
  end

  // Clamp the quotient; a negative sum clamps to zero
  always_comb begin
    if (neg_r) begin
      filt = '0;
    end else if (|quo_r[MAG_W-1:PIX_W]) begin
      filt = PIX_MAX;
    end else begin
      filt = quo_r[PIX_W-1:0];
    end
    center = en_r ? filt : win_r[1];
  end

  // Output word mux
  always_comb begin
    sel_pix = center;
    sel_rl  = 1'b0;
    sel_fl  = 1'b0;
    unique case (cmd.out_sel)
      SEL_CENTER: sel_pix = center;
      SEL_W0:     sel_pix = win_r[0];
      SEL_CUR: begin
        sel_pix = cur_r;
        sel_rl  = last_r;
        sel_fl  = last_r & fend_r;
      end
      default:    sel_pix = center;
    endcase
  end

  // Output register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pix_r <= sel_pix;
      out_rl_r  <= sel_rl;
      out_fl_r  <= sel_fl;
    end
  end

  assign out_valid  = out_valid_r;
  assign pixel_out  = out_pix_r;
  assign row_last   = out_rl_r;
  assign frame_last = out_fl_r;

endmodule

// File: hdl/hfir_ctrl.sv
// ----------------------------------------------------------------------------
// hfir_ctrl: sequencer of the horizontal luma filter
// Walks one word through capture, MAC, divide, result emission and the
// window shift, and drives the input stall.
// ----------------------------------------------------------------------------
module hfir_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hfir_pkg::hfir_sts_t sts,
  output hfir_pkg::hfir_cmd_t cmd
);
  import hfir_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_MAC      = 8'b0000_0010,
    ST_DSET     = 8'b0000_0100,
    ST_DIV      = 8'b0000_1000,
    ST_EMIT_C   = 8'b0001_0000,
    ST_EMIT_W0  = 8'b0010_0000,
    ST_EMIT_CUR = 8'b0100_0000,
    ST_SHIFT    = 8'b1000_0000
  } hfir_state_t;

  hfir_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != ST_IDLE;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.out_sel   = SEL_CENTER;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          priority if (sts.col_ge4 && sts.filter_on) begin
            state_nxt = ST_MAC;
          end else if (sts.col_ge4) begin
            state_nxt = ST_EMIT_C;
          end else if (sts.col_last) begin
            state_nxt = ST_EMIT_W0;
          end else if (sts.col_lt2) begin
            state_nxt = ST_EMIT_CUR;
          end else begin
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        if (sts.mac_done) state_nxt = ST_DSET;
      end
      ST_DSET: begin
        cmd.div_setup = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_EMIT_C;
      end
      ST_EMIT_C: begin
        cmd.out_sel = SEL_CENTER;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sts.item_last ? ST_EMIT_W0 : ST_SHIFT;
        end
      end
      ST_EMIT_W0: begin
        cmd.out_sel = SEL_W0;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_EMIT_CUR;
        end
      end
      ST_EMIT_CUR: begin
        cmd.out_sel = SEL_CUR;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Checks
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output register loaded while a word is held");

  a_capture_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cmd.capture) |=> in_stall)
    else $error("input not stalled after capture");

  a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cmd.div_step && sts.div_done) |=> (state_r == ST_EMIT_C))
    else $error("divide did not hand over to center emission");

  a_shift_once: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cmd.shift) |=> !cmd.shift && !in_stall)
    else $error("window shift not followed by idle");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.mac_step, cmd.div_setup, cmd.div_step,
              cmd.load_out, cmd.shift}))
    else $error("more than one datapath command at once");

endmodule

// File: hdl/horizontal_5tap_luma_fir_core.sv
// ----------------------------------------------------------------------------
// horizontal_5tap_luma_fir_core: horizontal five-tap luma filter
// Streams 8-bit luma in row order, filters the inner pixels of each row.
//
// Input channel (in_valid / in_stall): one pixel word per accept, with
// a frame end flag that counts only on the last pixel of a row.
// Output channel (out_valid / out_stall): filtered or copied pixels in
// row order with row and frame end flags; a word is taken when out_valid
// is high and out_stall is low.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 enable,
// 1 line width, 2..6 tap weights. Write only while the block is idle.
// Sequence: one pixel in flight at a time. A filtered pixel passes through
// accept, 5 MAC steps, divider setup, 18 divide steps (one quotient
// bit each), emit and window shift. Copied or silent pixels skip the MAC
// and divider; a row end emits its extra results in turn. The first
// result shows in the output register the cycle after it is loaded.
// A stalled receiver holds the output word and the sequencer, which
// stalls the input in turn. Reset clears the window, column counter and
// config registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module horizontal_5tap_luma_fir_core #(
  parameter int MAX_LINE_WIDTH = hfir_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hfir_pkg::PIX_W-1:0]     in_pixel_in,
  input  logic                           in_frame_end_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hfir_pkg::PIX_W-1:0]     out_pixel_out,
  output logic                           out_row_last,
  output logic                           out_frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hfir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfir_pkg::CFG_W-1:0]     cfg_data
);
  import hfir_pkg::*;

  hfir_cmd_t cmd;
  hfir_sts_t sts;

  assign cfg_ready = 1'b1;

  hfir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hfir_dp #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_in     (in_pixel_in),
    .frame_end_in (in_frame_end_in),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .pixel_out    (out_pixel_out),
    .row_last     (out_row_last),
    .frame_last   (out_frame_last),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

endmodule
